// ----- src/glmf_pkg.sv -----
package glmf_pkg;

    localparam int MAX_ROWS_DEF   = 64;
    localparam int MAX_COLS_DEF   = 64;
    localparam int PIXEL_BITS_DEF = 16;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = CFG_IDX_W'(1);

    localparam int POS_W     = 6;
    localparam int M_TDATA_W = 16;

    localparam int RES_PER_PIX = 3;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } res_t;

    typedef struct packed {
        logic [RES_PER_PIX-1:0] valid;
        res_t [RES_PER_PIX-1:0] item;
    } res_group_t;

endpackage

// ----- src/glmf_cell.sv -----
module glmf_cell #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         shift_en,
    input  logic         load_sel,
    input  logic [W-1:0] shift_in,
    input  logic [W-1:0] load_in,
    output logic [W-1:0] value
);

    logic [W-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            value_reg <= load_sel ? load_in : shift_in;
        end
    end

    assign value = value_reg;

endmodule

// ----- src/glmf_line.sv -----
module glmf_line #(
    parameter int W   = 16,
    parameter int LEN = 64,
    parameter int IW  = 6
) (
    input  logic          clk,
    input  logic          shift_en,
    input  logic [IW-1:0] entry,
    input  logic [W-1:0]  din,
    output logic [W-1:0]  tail,
    output logic [W-1:0]  near_tail
);

    logic [W-1:0] tap [LEN];

    for (genvar k = 0; k < LEN; k++)
    begin : g_cell
        logic [W-1:0] feed;

        if (k == 0)
        begin : g_head
            assign feed = din;
        end
        else
        begin : g_body
            assign feed = tap[k-1];
        end

        glmf_cell #(
            .W(W)
        ) u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .load_sel (entry == IW'(k)),
            .shift_in (feed),
            .load_in  (din),
            .value    (tap[k])
        );
    end

    assign tail = tap[LEN-1];

    if (LEN >= 2)
    begin : g_near
        assign near_tail = tap[LEN-2];
    end
    else
    begin : g_near_din
        assign near_tail = din;
    end

endmodule

// ----- src/glmf_result_queue.sv -----
module glmf_result_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  glmf_pkg::res_group_t push,
    output glmf_pkg::res_t      head,
    output logic                head_valid,
    input  logic                pop_ready,
    output logic                space_ok
);

    import glmf_pkg::*;

    res_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] slot [RES_PER_PIX];
    logic [QCNT_W-1:0] npush;
    logic              pop;

    always_comb
    begin
        slot[0] = wr_ptr_reg;
        slot[1] = wr_ptr_reg + QPTR_W'(push.valid[0]);
        slot[2] = wr_ptr_reg + QPTR_W'(push.valid[0]) + QPTR_W'(push.valid[1]);
        npush   = QCNT_W'($countones(push.valid));
    end

    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;
    assign space_ok   = (count_reg <= QCNT_W'(QDEPTH - RES_PER_PIX));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(npush);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + npush - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RES_PER_PIX; i++)
        begin
            if (push.valid[i])
            begin
                mem_reg[slot[i]] <= push.item[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/grid_local_maximum_finder_top.sv -----
// Local maximum finder, 4-neighbor, over a raster-order pixel stream.
// Slave stream (s_tvalid/s_tready/s_tdata): one signed pixel per transfer,
// row by row, frame_rows x frame_cols pixels per frame.
// Master stream (m_tvalid/m_tready/m_tdata/m_tlast): one peak position per
// transfer; m_tlast marks the final result caused by one input pixel.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 sets
// frame_rows, index 1 sets frame_cols; a write to either restarts the
// frame. Write only while the block is idle. cfg_ready is always high.
// Results of a pixel queue behind any waiting results. Throughput: one
// pixel per cycle while s_tready is high, set by the cell chains that
// shift once per pixel. A pixel in the last row can cause up to three
// results; s_tready drops while two or more results wait in the 4-entry
// result queue, so a stalled receiver backs up into the pixel stream.
// Reset: counters, neighbor registers and queue clear; frame size returns
// to MAX_ROWS x MAX_COLS. Line cells are not cleared: every cell read is
// written earlier in the same frame.
module grid_local_maximum_finder_top #(
    parameter int MAX_ROWS   = glmf_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = glmf_pkg::MAX_COLS_DEF,
    parameter int PIXEL_BITS = glmf_pkg::PIXEL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]     s_tdata,   // pixel_value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [glmf_pkg::M_TDATA_W-1:0]      m_tdata,   // peak_row, peak_col
    output logic                                m_tlast,   // last_of_run
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [glmf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [glmf_pkg::CFG_W-1:0]          cfg_data
);

    import glmf_pkg::*;

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] last_row_reg, last_row_next;
    logic [CW-1:0] last_col_reg, last_col_next;
    logic [CW-1:0] entry_reg, entry_next;

    logic signed [PIXEL_BITS-1:0] pix;
    logic signed [PIXEL_BITS-1:0] prev_reg, prev2_reg, d_cp1_reg;
    logic signed [PIXEL_BITS-1:0] d_c, d_cm1, d_2c;
    logic [PIXEL_BITS-1:0]        l1_tail, l1_near, l2_tail, l2_near;

    logic       accept;
    logic       cfg_wr;
    logic       restart;
    logic       space_ok;
    logic       r_ge1, r_ge2, c_ge1, c_ge2;
    logic       r_is_last, c_is_last;
    logic       ok_a, ok_b, ok_c;
    logic [RW-1:0] row_dec;
    logic [CW-1:0] col_dec;
    res_group_t push;
    res_t       head;
    logic       head_valid;

    assign pix       = $signed(s_tdata[PIXEL_BITS-1:0]);
    assign s_tready  = space_ok;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign restart   = cfg_wr && ((cfg_index == CFG_FRAME_ROWS) || (cfg_index == CFG_FRAME_COLS));

    glmf_line #(
        .W   (PIXEL_BITS),
        .LEN (MAX_COLS),
        .IW  (CW)
    ) u_line_near (
        .clk       (clk),
        .shift_en  (accept),
        .entry     (entry_reg),
        .din       (s_tdata[PIXEL_BITS-1:0]),
        .tail      (l1_tail),
        .near_tail (l1_near)
    );

    glmf_line #(
        .W   (PIXEL_BITS),
        .LEN (MAX_COLS),
        .IW  (CW)
    ) u_line_far (
        .clk       (clk),
        .shift_en  (accept),
        .entry     (entry_reg),
        .din       (l1_tail),
        .tail      (l2_tail),
        .near_tail (l2_near)
    );

    assign d_c   = $signed(l1_tail);
    assign d_cm1 = $signed(l1_near);
    assign d_2c  = $signed(l2_tail);

    always_comb
    begin
        last_row_next = last_row_reg;
        last_col_next = last_col_reg;
        if (cfg_wr && (cfg_index == CFG_FRAME_ROWS))
        begin
            priority if (cfg_data == '0)
                last_row_next = '0;
            else if (32'(cfg_data) > MAX_ROWS)
                last_row_next = RW'(MAX_ROWS - 1);
            else
                last_row_next = RW'(cfg_data - CFG_W'(1));
        end
        if (cfg_wr && (cfg_index == CFG_FRAME_COLS))
        begin
            priority if (cfg_data == '0)
                last_col_next = '0;
            else if (32'(cfg_data) > MAX_COLS)
                last_col_next = CW'(MAX_COLS - 1);
            else
                last_col_next = CW'(cfg_data - CFG_W'(1));
        end
        entry_next = CW'(MAX_COLS - 1) - last_col_next;
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        priority if (restart)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == last_col_reg)
            begin
                col_next = '0;
                row_next = (row_reg == last_row_reg) ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        r_ge1     = (row_reg != '0);
        r_ge2     = ({1'b0, row_reg} >= (RW+1)'(2));
        c_ge1     = (col_reg != '0);
        c_ge2     = ({1'b0, col_reg} >= (CW+1)'(2));
        r_is_last = (row_reg == last_row_reg);
        c_is_last = (col_reg == last_col_reg);
        row_dec   = row_reg - RW'(1);
        col_dec   = col_reg - CW'(1);

        ok_a = r_ge1 && (d_c >= pix)
            && !(r_ge2 && (d_c < d_2c))
            && !(c_ge1 && (d_c < d_cp1_reg))
            && !(!c_is_last && (d_c < d_cm1));
        ok_b = r_is_last && c_ge1 && (prev_reg >= pix)
            && !(c_ge2 && (prev_reg < prev2_reg))
            && !(r_ge1 && (prev_reg < d_cp1_reg));
        ok_c = r_is_last && c_is_last
            && !(c_ge1 && (pix < prev_reg))
            && !(r_ge1 && (pix < d_c));

        push.valid        = {ok_c, ok_b, ok_a} & {RES_PER_PIX{accept}};
        push.item[0].row  = POS_W'(row_dec);
        push.item[0].col  = POS_W'(col_reg);
        push.item[0].last = !ok_b && !ok_c;
        push.item[1].row  = POS_W'(row_reg);
        push.item[1].col  = POS_W'(col_dec);
        push.item[1].last = !ok_c;
        push.item[2].row  = POS_W'(row_reg);
        push.item[2].col  = POS_W'(col_reg);
        push.item[2].last = 1'b1;
    end

    glmf_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .head       (head),
        .head_valid (head_valid),
        .pop_ready  (m_tready),
        .space_ok   (space_ok)
    );

    assign m_tvalid = head_valid;
    assign m_tdata  = {{(M_TDATA_W - 2*POS_W){1'b0}}, head.col, head.row};
    assign m_tlast  = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            last_row_reg <= RW'(MAX_ROWS - 1);
            last_col_reg <= CW'(MAX_COLS - 1);
            entry_reg    <= '0;
            prev_reg     <= '0;
            prev2_reg    <= '0;
            d_cp1_reg    <= '0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            last_row_reg <= last_row_next;
            last_col_reg <= last_col_next;
            entry_reg    <= entry_next;
            if (accept)
            begin
                prev_reg  <= pix;
                prev2_reg <= prev_reg;
                d_cp1_reg <= d_c;
            end
        end
    end

endmodule

// ----- src/glmf_checker.sv -----
module glmf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [glmf_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result appeared without a pixel transfer");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input held off with no result pending");

    a_run_complete: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("run of results broken before tlast");

endmodule

bind grid_local_maximum_finder_top glmf_checker u_glmf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/tb_grid_local_maximum_finder_top.sv -----
`timescale 1ns / 1ps

module tb_grid_local_maximum_finder_top;
    import glmf_pkg::*;

    localparam int MAX_DIM      = 64;
    localparam int PIXEL_W      = 16;
    localparam int LIMIT_CYCLES = 300000;
    localparam int HOLD_CYCLES  = 240;
    localparam int PIXEL_BUDGET = 470;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

    typedef enum int {PIX_FULL, PIX_NEAR, PIX_EXTREME, PIX_MIXED} pixel_mix_t;

    typedef struct {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } peak_t;

    class peak_tracker_t;
        logic signed [PIXEL_W-1:0] lines [2][MAX_DIM];
        logic signed [PIXEL_W-1:0] prev_px;
        logic signed [PIXEL_W-1:0] prev2_px;
        logic [POS_W-1:0]          row_pos;
        logic [POS_W-1:0]          col_pos;
        logic [CFG_W-1:0]          rows;
        logic [CFG_W-1:0]          cols;
        peak_t                     expected_peaks [$];
        int                        errors;

        function new();
            foreach (lines[i, j])
                lines[i][j] = '0;
            prev_px  = '0;
            prev2_px = '0;
            row_pos  = '0;
            col_pos  = '0;
            rows     = CFG_W'(MAX_DIM);
            cols     = CFG_W'(MAX_DIM);
            errors   = 0;
        endfunction

        function int pending();
            return expected_peaks.size();
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            logic [CFG_W-1:0] size;
            size = (val == 0) ? CFG_W'(1) : (val > MAX_DIM) ? CFG_W'(MAX_DIM) : val;
            if (idx == CFG_FRAME_ROWS)
                rows = size;
            else if (idx == CFG_FRAME_COLS)
                cols = size;
            else
                return;
            row_pos = '0;
            col_pos = '0;
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] raw);
            logic signed [PIXEL_W-1:0] x;
            logic signed [PIXEL_W-1:0] ctr;
            logic [POS_W-1:0]          r;
            logic [POS_W-1:0]          c;
            logic                      b;
            logic                      pb;
            logic                      ok;
            peak_t                     found [$];
            x = raw;
            r = row_pos;
            c = col_pos;
            if (r >= rows)
                r = POS_W'(rows - 1);
            if (c >= cols)
                c = POS_W'(cols - 1);
            b  = r[0];
            pb = ~b;

            if (r >= 1)
            begin
                ctr = lines[pb][c];
                ok  = (ctr >= x);
                if (r >= 2 && ctr < lines[b][c])
                    ok = 1'b0;
                if (c >= 1 && ctr < lines[pb][c - 1])
                    ok = 1'b0;
                if (c + 1 < cols && ctr < lines[pb][c + 1])
                    ok = 1'b0;
                if (ok)
                    found.push_back('{row: POS_W'(r - 1), col: c, last: 1'b0});
            end
            lines[b][c] = x;

            if (r == rows - 1)
            begin
                if (c >= 1)
                begin
                    ctr = prev_px;
                    ok  = (ctr >= x);
                    if (c >= 2 && ctr < prev2_px)
                        ok = 1'b0;
                    if (r >= 1 && ctr < lines[pb][c - 1])
                        ok = 1'b0;
                    if (ok)
                        found.push_back('{row: r, col: POS_W'(c - 1), last: 1'b0});
                end
                if (c == cols - 1)
                begin
                    ok = 1'b1;
                    if (c >= 1 && x < prev_px)
                        ok = 1'b0;
                    if (r >= 1 && x < lines[pb][c])
                        ok = 1'b0;
                    if (ok)
                        found.push_back('{row: r, col: c, last: 1'b0});
                end
            end

            prev2_px = prev_px;
            prev_px  = x;

            if (c + 1 >= cols)
            begin
                col_pos = '0;
                row_pos = (r + 1 >= rows) ? '0 : POS_W'(r + 1);
            end
            else
            begin
                col_pos = POS_W'(c + 1);
                row_pos = r;
            end

            if (found.size() > 0)
                found[found.size() - 1].last = 1'b1;
            foreach (found[i])
                expected_peaks.push_back(found[i]);
        endfunction

        function void check_peak(logic [M_TDATA_W-1:0] data, logic last);
            peak_t want;
            if (expected_peaks.size() == 0)
            begin
                $display("%0t: unexpected peak: actual row %0d col %0d last %0b",
                         $time, data[POS_W-1:0], data[2*POS_W-1:POS_W], last);
                errors++;
                return;
            end
            want = expected_peaks.pop_front();
            if (data[POS_W-1:0] !== want.row)
            begin
                $display("%0t: peak_row mismatch: expected %0d actual %0d",
                         $time, want.row, data[POS_W-1:0]);
                errors++;
            end
            if (data[2*POS_W-1:POS_W] !== want.col)
            begin
                $display("%0t: peak_col mismatch: expected %0d actual %0d",
                         $time, want.col, data[2*POS_W-1:POS_W]);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_of_run mismatch: expected %0b actual %0b",
                         $time, want.last, last);
                errors++;
            end
            if (data[M_TDATA_W-1:2*POS_W] !== '0)
            begin
                $display("%0t: tdata padding mismatch: expected 0 actual %h",
                         $time, data[M_TDATA_W-1:2*POS_W]);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [PIXEL_W-1:0]     s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;

    peak_tracker_t board;
    int            idle_pct = 11;
    bit            hold_req = 1'b0;
    int            cycles   = 0;

    grid_local_maximum_finder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.apply_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                board.note_pixel(s_tdata);
            if (m_tvalid && m_tready)
                board.check_peak(m_tdata, m_tlast);
        end
    end

    // hold off the result stream for a long stretch on request
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    function automatic logic [PIXEL_W-1:0] pick_pixel(pixel_mix_t mix);
        case (mix)
            PIX_FULL:
                return PIXEL_W'($urandom);
            PIX_NEAR:
                return PIXEL_W'($urandom_range(0, 4) - 2);
            PIX_EXTREME:
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            default:
                return pick_pixel(pixel_mix_t'($urandom_range(0, 2)));
        endcase
    endfunction

    task automatic send_pixel(input logic [PIXEL_W-1:0] px);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // drop the pixel stream and drain every outstanding peak
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic configure(input logic [CFG_W-1:0] rows_v, input logic [CFG_W-1:0] cols_v,
                             input bit stray);
        if (stray)
            set_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), CFG_W'($urandom));
        set_reg(CFG_FRAME_ROWS, rows_v);
        set_reg(CFG_FRAME_COLS, cols_v);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int               budget;
        int               phase;
        int               n;
        int               eff_rows;
        int               eff_cols;
        logic [CFG_W-1:0] rows_v;
        logic [CFG_W-1:0] cols_v;
        pixel_mix_t       mix;

        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(16'h7FFF);
        send_pixel(16'h8000);
        send_pixel(16'h0001);
        settle();

        configure(7'd1, 7'd1, 1'b0);
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);
        settle();

        configure(7'd0, 7'd3, 1'b0);
        send_pixel(16'h0001);
        send_pixel(16'h7FFF);
        send_pixel(16'h8000);
        settle();

        configure(7'd2, 7'd0, 1'b0);
        send_pixel(16'h8000);
        send_pixel(16'h8000);
        settle();

        configure(7'd3, 7'd3, 1'b0);
        repeat (4) send_pixel(16'h1234);
        settle();
        set_reg(CFG_UNUSED_HI, 7'h7F);
        set_reg(CFG_UNUSED_LO, 7'h00);
        cfg_valid <= 1'b0;
        repeat (5) send_pixel(16'h1234);
        settle();

        configure(7'd100, 7'd127, 1'b1);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);
        settle();

        budget = PIXEL_BUDGET;
        phase  = 0;
        while (budget > 0)
        begin
            rows_v = CFG_W'($urandom_range(1, 8));
            cols_v = CFG_W'($urandom_range(1, 8));
            case ($urandom_range(0, 9))
                0:
                begin
                    rows_v = CFG_W'($urandom_range(0, 127));
                    cols_v = CFG_W'($urandom_range(1, 2));
                end
                1:
                begin
                    cols_v = CFG_W'($urandom_range(0, 127));
                    rows_v = CFG_W'($urandom_range(1, 2));
                end
                2: rows_v = 7'd1;
                3: cols_v = 7'd1;
                default: ;
            endcase
            if (phase == 2)
            begin
                rows_v = 7'd4;
                cols_v = 7'd8;
            end
            configure(rows_v, cols_v, $urandom_range(0, 7) == 0);

            eff_rows = (rows_v == 0) ? 1 : (rows_v > MAX_DIM) ? MAX_DIM : int'(rows_v);
            eff_cols = (cols_v == 0) ? 1 : (cols_v > MAX_DIM) ? MAX_DIM : int'(cols_v);
            n = eff_rows * eff_cols * $urandom_range(1, 3);
            if (n > 160)
                n = $urandom_range(20, 160);
            if (phase == 1 && n < 80)
                n = 80;
            mix = pixel_mix_t'($urandom_range(0, 3));
            if (phase == 2)
            begin
                n   = 96;
                mix = PIX_NEAR;
            end
            if (n > budget)
                n = budget;

            idle_pct = (phase == 1) ? 0 : 11;
            hold_req = (phase == 2);
            repeat (n) send_pixel(pick_pixel(mix));
            settle();
            budget -= n;
            phase++;
        end

        idle_pct = 11;
        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("Test completed successfully");
        else
        begin
            if (board.pending() != 0)
                $display("%0t: %0d expected peaks never arrived", $time, board.pending());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/glmf_pkg.sv
src/glmf_cell.sv
src/glmf_line.sv
src/glmf_result_queue.sv
src/grid_local_maximum_finder_top.sv
src/glmf_checker.sv
tb/tb_grid_local_maximum_finder_top.sv
